FILE: sv/mhs_pkg.sv
`timescale 1ns / 1ps
package mhs_pkg;

	localparam int RAW_W       = 16;
	localparam int SCALED_W    = 25;
	localparam int GAIN_W      = 9;
	localparam int RANGE_W     = 3;
	localparam int CW          = 28;
	localparam int ZW          = 29;
	localparam int ANGLE_W     = 16;
	localparam int CDEG_W      = 16;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int ATAN_LEN    = 24;
	localparam int ATAN_IDX_W  = 5;
	localparam int CDEG_MUL_W  = 24;

	localparam int ANGLE_ITERATIONS_DEF = 16;

	localparam int PI_Q24     = 52707179;
	localparam int PI_Q13     = 25736;
	localparam int TWO_PI_Q13 = 51472;
	localparam int CDEG_MUL   = 11734176;
	localparam int ROUND_Q13  = 1024;
	localparam int ROUND_SH   = 11;
	localparam int CDEG_SH    = 24;

	localparam logic [CFG_INDEX_W-1:0] REG_RANGE_CODE  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_DECLINATION = 2'd1;

	localparam logic [RANGE_W-1:0]           RANGE_RESET = 3'd1;
	localparam logic signed [CFG_DATA_W-1:0] DECL_RESET  = -16'sd1266;

	typedef struct packed {
		logic signed [SCALED_W-1:0] z;
		logic signed [SCALED_W-1:0] y;
		logic signed [SCALED_W-1:0] x;
	} scaled_t;

	typedef struct packed {
		scaled_t              sc;
		logic                 zero;
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [ZW-1:0] z;
	} cordic_t;

	function automatic logic [GAIN_W-1:0] gain_lut(input logic [RANGE_W-1:0] code);
		logic [GAIN_W-1:0] g;
		unique case (code)
			3'd0: g = 9'd73;
			3'd1: g = 9'd92;
			3'd2: g = 9'd122;
			3'd3: g = 9'd152;
			3'd4: g = 9'd227;
			3'd5: g = 9'd256;
			3'd6: g = 9'd303;
			default: g = 9'd435;
		endcase
		return g;
	endfunction

	function automatic logic signed [ZW-1:0] atan_lut(input logic [ATAN_IDX_W-1:0] i);
		logic signed [ZW-1:0] a;
		unique case (i)
			5'd0:  a = 29'sd13176795;
			5'd1:  a = 29'sd7778716;
			5'd2:  a = 29'sd4110060;
			5'd3:  a = 29'sd2086331;
			5'd4:  a = 29'sd1047214;
			5'd5:  a = 29'sd524117;
			5'd6:  a = 29'sd262123;
			5'd7:  a = 29'sd131069;
			5'd8:  a = 29'sd65536;
			5'd9:  a = 29'sd32768;
			5'd10: a = 29'sd16384;
			5'd11: a = 29'sd8192;
			5'd12: a = 29'sd4096;
			5'd13: a = 29'sd2048;
			5'd14: a = 29'sd1024;
			5'd15: a = 29'sd512;
			5'd16: a = 29'sd256;
			5'd17: a = 29'sd128;
			5'd18: a = 29'sd64;
			5'd19: a = 29'sd32;
			5'd20: a = 29'sd16;
			5'd21: a = 29'sd8;
			5'd22: a = 29'sd4;
			5'd23: a = 29'sd2;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

FILE: sv/mhs_scale.sv
`timescale 1ns / 1ps
module mhs_scale import mhs_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [RANGE_W-1:0]        range_code,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [RAW_W-1:0]   x_raw,
	input  logic signed [RAW_W-1:0]   y_raw,
	input  logic signed [RAW_W-1:0]   z_raw,
	output logic                      out_valid,
	input  logic                      out_ready,
	output cordic_t                   out_data
);

	logic                       valid_s1;
	logic                       valid_s2;
	logic                       ready_s1;
	logic                       ready_s2;
	scaled_t                    sc_s1;
	cordic_t                    cd_s2;
	logic signed [GAIN_W:0]     gain;
	logic signed [RAW_W+GAIN_W:0] px, py, pz;
	cordic_t                    pre;
	logic signed [CW-1:0]       xe, ye;

	assign ready_s2 = !valid_s2 || out_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	// gain multiply
	always_comb begin
		gain = $signed({1'b0, gain_lut(range_code)});
		px   = (RAW_W+GAIN_W+1)'(x_raw) * (RAW_W+GAIN_W+1)'(gain);
		py   = (RAW_W+GAIN_W+1)'(y_raw) * (RAW_W+GAIN_W+1)'(gain);
		pz   = (RAW_W+GAIN_W+1)'(z_raw) * (RAW_W+GAIN_W+1)'(gain);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			sc_s1.x <= SCALED_W'(px);
			sc_s1.y <= SCALED_W'(py);
			sc_s1.z <= SCALED_W'(pz);
		end
	end

	// fold left half plane onto the right half
	always_comb begin
		xe       = CW'(sc_s1.x);
		ye       = CW'(sc_s1.y);
		pre.sc   = sc_s1;
		pre.zero = (sc_s1.x == '0) && (sc_s1.y == '0);
		if (sc_s1.x < 0) begin
			pre.x = -xe;
			pre.y = -ye;
			pre.z = (sc_s1.y >= 0) ? ZW'(PI_Q24) : -ZW'(PI_Q24);
		end else begin
			pre.x = xe;
			pre.y = ye;
			pre.z = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			cd_s2 <= pre;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = cd_s2;

endmodule

FILE: sv/mhs_cordic_stage.sv
`timescale 1ns / 1ps
module mhs_cordic_stage import mhs_pkg::*; #(
	parameter int SHIFT = 0
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  cordic_t in_data,
	output logic    out_valid,
	input  logic    out_ready,
	output cordic_t out_data
);

	logic                 valid_q;
	cordic_t              data_q;
	cordic_t              nxt;
	logic signed [CW-1:0] dx, dy;
	logic signed [ZW-1:0] a;

	assign in_ready = !valid_q || out_ready;

	// one micro-rotation toward y = 0
	always_comb begin
		dx       = in_data.y >>> SHIFT;
		dy       = in_data.x >>> SHIFT;
		a        = atan_lut(ATAN_IDX_W'(SHIFT));
		nxt.sc   = in_data.sc;
		nxt.zero = in_data.zero;
		if (in_data.y > 0) begin
			nxt.x = in_data.x + dx;
			nxt.y = in_data.y - dy;
			nxt.z = in_data.z + a;
		end else begin
			nxt.x = in_data.x - dx;
			nxt.y = in_data.y + dy;
			nxt.z = in_data.z - a;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

FILE: sv/mhs_heading.sv
`timescale 1ns / 1ps
module mhs_heading import mhs_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic signed [CFG_DATA_W-1:0]  declination,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  cordic_t                       in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output scaled_t                       out_scaled,
	output logic [ANGLE_W-1:0]            out_radians,
	output logic [CDEG_W-1:0]             out_cdeg
);

	localparam int PW = ANGLE_W + CDEG_MUL_W;

	logic                     valid_s1;
	logic                     valid_s2;
	logic                     ready_s1;
	logic                     ready_s2;
	scaled_t                  sc_s1;
	scaled_t                  sc_s2;
	logic [ANGLE_W-1:0]       h_s1;
	logic [ANGLE_W-1:0]       h_s2;
	logic [CDEG_W-1:0]        cdeg_s2;
	logic signed [ZW:0]       zr;
	logic signed [ZW:0]       zsh;
	logic signed [ANGLE_W:0]  ang;
	logic signed [ANGLE_W:0]  hs;
	logic [PW-1:0]            prod;

	assign ready_s2 = !valid_s2 || out_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	// round to 2^-13 rad, saturate, add declination, wrap
	always_comb begin
		zr  = (ZW+1)'(in_data.z) + (ZW+1)'(ROUND_Q13);
		zsh = zr >>> ROUND_SH;
		if (in_data.zero) begin
			ang = '0;
		end else if (zsh > (ZW+1)'(PI_Q13)) begin
			ang = (ANGLE_W+1)'(PI_Q13);
		end else if (zsh < -(ZW+1)'(PI_Q13)) begin
			ang = -(ANGLE_W+1)'(PI_Q13);
		end else begin
			ang = (ANGLE_W+1)'(zsh);
		end
		hs = ang + (ANGLE_W+1)'(declination);
		if (hs < 0) begin
			hs = hs + (ANGLE_W+1)'(TWO_PI_Q13);
		end else if (hs > (ANGLE_W+1)'(TWO_PI_Q13)) begin
			hs = hs - (ANGLE_W+1)'(TWO_PI_Q13);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			sc_s1 <= in_data.sc;
			h_s1  <= ANGLE_W'(hs);
		end
	end

	// radians to centidegrees
	always_comb begin
		prod = PW'(h_s1) * PW'(CDEG_MUL) + PW'(1 << (CDEG_SH - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			sc_s2   <= sc_s1;
			h_s2    <= h_s1;
			cdeg_s2 <= CDEG_W'(prod >> CDEG_SH);
		end
	end

	assign out_valid   = valid_s2;
	assign out_scaled  = sc_s2;
	assign out_radians = h_s2;
	assign out_cdeg    = cdeg_s2;

endmodule

FILE: sv/magnetometer_scale_and_heading_top.sv
`timescale 1ns / 1ps
// pipeline from accepted input word to output word: gain multiply, quadrant fold,
// one cordic stage per iteration, heading, centidegrees
// throughput: one word per cycle while not stalled; every stage has its own valid and ready
// reset: pipeline valids cleared, range_code = 1, declination = -1266
module magnetometer_scale_and_heading_top import mhs_pkg::*; #(
	parameter int ANGLE_ITERATIONS = ANGLE_ITERATIONS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [47:0]            s_tdata,   // x_raw, y_raw, z_raw
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [111:0]           m_tdata,   // x_scaled, y_scaled, z_scaled,
	                                          // heading_radians, heading_centidegrees, zero pad
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic [RANGE_W-1:0]          range_q;
	logic signed [CFG_DATA_W-1:0] decl_q;
	logic signed [CFG_DATA_W-1:0] cfg_sdata;

	logic    c_valid [0:ANGLE_ITERATIONS];
	logic    c_ready [0:ANGLE_ITERATIONS];
	cordic_t c_data  [0:ANGLE_ITERATIONS];

	scaled_t            sc_out;
	logic [ANGLE_W-1:0] rad_out;
	logic [CDEG_W-1:0]  cdeg_out;

	assign cfg_ready = 1'b1;
	assign cfg_sdata = $signed(cfg_data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_q <= RANGE_RESET;
			decl_q  <= DECL_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == REG_RANGE_CODE) begin
				range_q <= cfg_data[RANGE_W-1:0];
			end else if (cfg_index == REG_DECLINATION) begin
				if (cfg_sdata > CFG_DATA_W'(PI_Q13)) begin
					decl_q <= CFG_DATA_W'(PI_Q13);
				end else if (cfg_sdata < -CFG_DATA_W'(PI_Q13)) begin
					decl_q <= -CFG_DATA_W'(PI_Q13);
				end else begin
					decl_q <= cfg_sdata;
				end
			end
		end
	end

	mhs_scale u_scale (
		.clk        (clk),
		.arst_n     (arst_n),
		.range_code (range_q),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.x_raw      (s_tdata[15:0]),
		.y_raw      (s_tdata[31:16]),
		.z_raw      (s_tdata[47:32]),
		.out_valid  (c_valid[0]),
		.out_ready  (c_ready[0]),
		.out_data   (c_data[0])
	);

	for (genvar k = 0; k < ANGLE_ITERATIONS; k++) begin : g_cordic
		mhs_cordic_stage #(
			.SHIFT (k)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (c_valid[k]),
			.in_ready  (c_ready[k]),
			.in_data   (c_data[k]),
			.out_valid (c_valid[k+1]),
			.out_ready (c_ready[k+1]),
			.out_data  (c_data[k+1])
		);
	end

	mhs_heading u_heading (
		.clk         (clk),
		.arst_n      (arst_n),
		.declination (decl_q),
		.in_valid    (c_valid[ANGLE_ITERATIONS]),
		.in_ready    (c_ready[ANGLE_ITERATIONS]),
		.in_data     (c_data[ANGLE_ITERATIONS]),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_scaled  (sc_out),
		.out_radians (rad_out),
		.out_cdeg    (cdeg_out)
	);

	assign m_tdata = {5'b0, cdeg_out, rad_out, sc_out.z, sc_out.y, sc_out.x};

endmodule
